### rtl/tmf_pkg.sv
// Shared constants, types and state encodings for the TLV message framer.
`default_nettype none

package tmf_pkg;

    // Buffer geometry.
    localparam int BUFFER_BYTES = 512;
    localparam int CAP_BYTES    = BUFFER_BYTES - (BUFFER_BYTES % 8);
    localparam int STORE_WORDS  = BUFFER_BYTES / 8;
    localparam int ADDR_W       = $clog2(STORE_WORDS);
    localparam int WCNT_W       = $clog2(STORE_WORDS + 1);
    localparam int OFS_W        = 10;
    localparam int FCNT_W       = 7;

    // Field layout sizes in bytes.
    localparam int HEADER_BYTES  = 16;
    localparam int INT16_BYTES   = 8;
    localparam int INT32_BYTES   = 16;
    localparam int STR_MIN_BYTES = 16;
    localparam int STR_HEAD_BYTES = 12;
    localparam int CHAR_BYTES    = 2;

    // Field type codes.
    localparam logic [7:0] TYPE_INT32  = 8'd0;
    localparam logic [7:0] TYPE_STRING = 8'd1;
    localparam logic [7:0] TYPE_INT16  = 8'd3;

    // Command queue depth (power of two).
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef enum logic [2:0] {
        MODE_START     = 3'd0,
        MODE_INT16     = 3'd1,
        MODE_INT32     = 3'd2,
        MODE_STR_BEGIN = 3'd3,
        MODE_STR_CHAR  = 3'd4,
        MODE_STR_END   = 3'd5,
        MODE_FINALIZE  = 3'd6
    } mode_t;

    typedef enum logic {
        CMD_WRITE = 1'b0,
        CMD_EMIT  = 1'b1
    } cmd_kind_t;

    // One queued operation for the back end: a byte-masked word write, or
    // a request to stream the message out.
    typedef struct packed {
        cmd_kind_t           kind;
        logic [ADDR_W-1:0]   addr;
        logic [7:0]          be;
        logic [63:0]         data;
        logic [WCNT_W-1:0]   words;
        logic [OFS_W-1:0]    total;
        logic                ovf;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } qstat_t;

    typedef enum logic [2:0] {
        F_IDLE,
        F_CLOSE_LEN,
        F_CLOSE_PAD,
        F_OP,
        F_OP2,
        F_EMIT
    } front_state_t;

    typedef enum logic {
        B_IDLE,
        B_LOAD
    } back_state_t;

endpackage

`default_nettype wire

### rtl/tmf_front.sv
// Front end: accepts items, tracks the message layout and issues write commands.
`default_nettype none

module tmf_front import tmf_pkg::*; (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [2:0]  mode,
    input  wire logic [31:0] field_id,
    input  wire logic [31:0] value,
    input  wire logic        cfg_we,
    input  wire logic        stamp_message_id,
    input  wire qstat_t      q_status,
    output logic             push,
    output cmd_t             push_cmd
);

    front_state_t        state_reg, state_next;
    mode_t               mode_reg, mode_next;
    logic [31:0]         fid_reg, fid_next;
    logic [31:0]         val_reg, val_next;
    logic [OFS_W-1:0]    offset_reg, offset_next;
    logic [FCNT_W-1:0]   count_reg, count_next;
    logic [15:0]         code_reg, code_next;
    logic [31:0]         id_reg, id_next;
    logic [OFS_W-1:0]    head_reg, head_next;
    logic [OFS_W-1:0]    len_reg, len_next;
    logic                ovf_reg, ovf_next;
    logic                stamp_reg;

    logic                in_fire;
    logic                str_open;
    mode_t               mode_in;
    logic [OFS_W:0]      ofs_ext;
    logic                fits_char, fits_int16, fits_16;
    logic [ADDR_W-1:0]   wa, wa1, head_wa1;
    logic [2:0]          pos;
    logic [2:0]          char_shift;

    assign in_ready = (state_reg == F_IDLE) && !q_status.full;
    assign in_fire  = in_valid && in_ready;
    assign str_open = (head_reg != '0);
    assign mode_in  = mode_t'(mode);

    // Space checks against the usable capacity.
    assign ofs_ext    = {1'b0, offset_reg};
    assign fits_char  = (ofs_ext + (OFS_W+1)'(CHAR_BYTES))  <= (OFS_W+1)'(CAP_BYTES);
    assign fits_int16 = (ofs_ext + (OFS_W+1)'(INT16_BYTES)) <= (OFS_W+1)'(CAP_BYTES);
    assign fits_16    = (ofs_ext + (OFS_W+1)'(INT32_BYTES)) <= (OFS_W+1)'(CAP_BYTES);

    // Word addresses and byte position of the write pointer.
    assign wa         = offset_reg[ADDR_W+2:3];
    assign wa1        = wa + 1'b1;
    assign head_wa1   = head_reg[ADDR_W+2:3] + 1'b1;
    assign pos        = offset_reg[2:0];
    assign char_shift = 3'd6 - pos;

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stamp_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            stamp_reg <= stamp_message_id;
        end
    end

    // Sequencer next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            F_IDLE:
            begin
                if (in_fire)
                begin
                    case (mode_in)
                        MODE_INT16, MODE_INT32, MODE_STR_BEGIN, MODE_FINALIZE:
                            state_next = str_open ? F_CLOSE_LEN : F_OP;
                        MODE_STR_END:
                            state_next = str_open ? F_CLOSE_LEN : F_IDLE;
                        default:
                            state_next = F_IDLE;
                    endcase
                end
            end
            F_CLOSE_LEN:
            begin
                if (!q_status.full)
                begin
                    state_next = F_CLOSE_PAD;
                end
            end
            F_CLOSE_PAD:
            begin
                if (!q_status.full)
                begin
                    state_next = (mode_reg == MODE_STR_END) ? F_IDLE : F_OP;
                end
            end
            F_OP:
            begin
                if (!q_status.full)
                begin
                    case (mode_reg)
                        MODE_INT32, MODE_STR_BEGIN:
                            state_next = fits_16 ? F_OP2 : F_IDLE;
                        MODE_FINALIZE:
                            state_next = F_OP2;
                        default:
                            state_next = F_IDLE;
                    endcase
                end
            end
            F_OP2:
            begin
                if (!q_status.full)
                begin
                    state_next = (mode_reg == MODE_FINALIZE) ? F_EMIT : F_IDLE;
                end
            end
            F_EMIT:
            begin
                if (!q_status.full)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
                state_next = F_IDLE;
        endcase
    end

    // Commands and layout state updates.
    always_comb
    begin
        push        = 1'b0;
        push_cmd    = '0;
        mode_next   = mode_reg;
        fid_next    = fid_reg;
        val_next    = val_reg;
        offset_next = offset_reg;
        count_next  = count_reg;
        code_next   = code_reg;
        id_next     = id_reg;
        head_next   = head_reg;
        len_next    = len_reg;
        ovf_next    = ovf_reg;
        case (state_reg)
            F_IDLE:
            begin
                if (in_fire)
                begin
                    mode_next = mode_in;
                    fid_next  = field_id;
                    val_next  = value;
                    case (mode_in)
                        MODE_START:
                        begin
                            code_next   = value[15:0];
                            count_next  = '0;
                            offset_next = OFS_W'(HEADER_BYTES);
                            head_next   = '0;
                            len_next    = '0;
                            ovf_next    = 1'b0;
                        end
                        MODE_STR_CHAR:
                        begin
                            if (str_open)
                            begin
                                if (fits_char)
                                begin
                                    // Zero byte then the character.
                                    push          = 1'b1;
                                    push_cmd.kind = CMD_WRITE;
                                    push_cmd.addr = wa;
                                    push_cmd.be   = 8'b0000_0011 << char_shift;
                                    push_cmd.data = 64'(value[7:0]) << {char_shift, 3'b000};
                                    offset_next   = offset_reg + OFS_W'(CHAR_BYTES);
                                    len_next      = len_reg + OFS_W'(CHAR_BYTES);
                                end
                                else
                                begin
                                    // Drop the whole string.
                                    offset_next = head_reg;
                                    head_next   = '0;
                                    len_next    = '0;
                                    ovf_next    = 1'b1;
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            F_CLOSE_LEN:
            begin
                if (!q_status.full)
                begin
                    // Patch the string length into its head.
                    push          = 1'b1;
                    push_cmd.kind = CMD_WRITE;
                    push_cmd.addr = head_wa1;
                    push_cmd.be   = 8'hF0;
                    push_cmd.data = {22'd0, len_reg, 32'd0};
                end
            end
            F_CLOSE_PAD:
            begin
                if (!q_status.full)
                begin
                    // Zero the rest of the current word.
                    push          = 1'b1;
                    push_cmd.kind = CMD_WRITE;
                    push_cmd.addr = wa;
                    push_cmd.be   = (pos == 3'd0) ? 8'h00 : (8'hFF >> pos);
                    push_cmd.data = '0;
                    offset_next   = {offset_reg[OFS_W-1:3] + (OFS_W-3)'(pos != 3'd0), 3'b000};
                    count_next    = count_reg + 1'b1;
                    head_next     = '0;
                    len_next      = '0;
                end
            end
            F_OP:
            begin
                if (!q_status.full)
                begin
                    case (mode_reg)
                        MODE_INT16:
                        begin
                            if (fits_int16)
                            begin
                                push          = 1'b1;
                                push_cmd.kind = CMD_WRITE;
                                push_cmd.addr = wa;
                                push_cmd.be   = 8'hFF;
                                push_cmd.data = {fid_reg, TYPE_INT16, 8'd0, val_reg[15:0]};
                                offset_next   = offset_reg + OFS_W'(INT16_BYTES);
                                count_next    = count_reg + 1'b1;
                            end
                            else
                            begin
                                ovf_next = 1'b1;
                            end
                        end
                        MODE_INT32:
                        begin
                            if (fits_16)
                            begin
                                push          = 1'b1;
                                push_cmd.kind = CMD_WRITE;
                                push_cmd.addr = wa;
                                push_cmd.be   = 8'hFF;
                                push_cmd.data = {fid_reg, TYPE_INT32, 24'd0};
                            end
                            else
                            begin
                                ovf_next = 1'b1;
                            end
                        end
                        MODE_STR_BEGIN:
                        begin
                            if (fits_16)
                            begin
                                push          = 1'b1;
                                push_cmd.kind = CMD_WRITE;
                                push_cmd.addr = wa;
                                push_cmd.be   = 8'hFF;
                                push_cmd.data = {fid_reg, TYPE_STRING, 24'd0};
                                head_next     = offset_reg;
                                len_next      = '0;
                            end
                            else
                            begin
                                ovf_next = 1'b1;
                            end
                        end
                        MODE_FINALIZE:
                        begin
                            // Header word: code, flags, size.
                            push          = 1'b1;
                            push_cmd.kind = CMD_WRITE;
                            push_cmd.addr = '0;
                            push_cmd.be   = 8'hFF;
                            push_cmd.data = {code_reg, 16'd0, 22'd0, offset_reg};
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            F_OP2:
            begin
                if (!q_status.full)
                begin
                    push          = 1'b1;
                    push_cmd.kind = CMD_WRITE;
                    push_cmd.addr = wa1;
                    case (mode_reg)
                        MODE_INT32:
                        begin
                            push_cmd.be   = 8'hFF;
                            push_cmd.data = {val_reg, 32'd0};
                            offset_next   = offset_reg + OFS_W'(INT32_BYTES);
                            count_next    = count_reg + 1'b1;
                        end
                        MODE_STR_BEGIN:
                        begin
                            // Length starts at zero; characters fill the low half.
                            push_cmd.be   = 8'hF0;
                            push_cmd.data = '0;
                            offset_next   = offset_reg + OFS_W'(STR_HEAD_BYTES);
                        end
                        MODE_FINALIZE:
                        begin
                            // Header word: message id and field count.
                            push_cmd.addr = ADDR_W'(1);
                            push_cmd.be   = 8'hFF;
                            push_cmd.data = {(stamp_reg ? id_reg : 32'd0),
                                             {(32-FCNT_W){1'b0}}, count_reg};
                            if (stamp_reg)
                            begin
                                id_next = id_reg + 32'd1;
                            end
                        end
                        default:
                        begin
                            push = 1'b0;
                        end
                    endcase
                end
            end
            F_EMIT:
            begin
                if (!q_status.full)
                begin
                    push           = 1'b1;
                    push_cmd.kind  = CMD_EMIT;
                    push_cmd.words = WCNT_W'(offset_reg >> 3);
                    push_cmd.total = offset_reg;
                    push_cmd.ovf   = ovf_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Control and layout state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= F_IDLE;
            offset_reg <= OFS_W'(HEADER_BYTES);
            count_reg  <= '0;
            code_reg   <= '0;
            id_reg     <= 32'd1;
            head_reg   <= '0;
            len_reg    <= '0;
            ovf_reg    <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            offset_reg <= offset_next;
            count_reg  <= count_next;
            code_reg   <= code_next;
            id_reg     <= id_next;
            head_reg   <= head_next;
            len_reg    <= len_next;
            ovf_reg    <= ovf_next;
        end
    end

    // Latched item payload.
    always_ff @(posedge clk)
    begin
        mode_reg <= mode_next;
        fid_reg  <= fid_next;
        val_reg  <= val_next;
    end

endmodule

`default_nettype wire

### rtl/tmf_cmd_fifo.sv
// Short command queue between the front end and the back end.
`default_nettype none

module tmf_cmd_fifo import tmf_pkg::*; (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire cmd_t push_cmd,
    input  wire logic pop,
    output cmd_t      pop_cmd,
    output qstat_t    status
);

    cmd_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   fill_reg, fill_next;

    assign status.full  = (fill_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign status.empty = (fill_reg == '0);
    assign pop_cmd      = slot_reg[rd_ptr_reg];

    // Pointer and fill count updates.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + QPTR_W'(push);
        rd_ptr_next = rd_ptr_reg + QPTR_W'(pop);
        fill_next   = fill_reg + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Queue slots.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

### rtl/tmf_back.sv
// Back end: message buffer memory, word writes and the output word stream.
`default_nettype none

module tmf_back import tmf_pkg::*; (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire qstat_t       q_status,
    input  wire cmd_t         q_cmd,
    output logic              pop,
    output logic              out_valid,
    input  wire logic         out_ready,
    output logic [63:0]       data_word,
    output logic              last_word,
    output logic [OFS_W-1:0]  total_bytes,
    output logic              overflowed
);

    logic [63:0]        mem [STORE_WORDS];
    logic [63:0]        rd_data_reg;

    back_state_t        state_reg, state_next;
    logic [ADDR_W-1:0]  idx_reg, idx_next;
    logic [WCNT_W-1:0]  words_reg, words_next;
    logic [OFS_W-1:0]   total_reg, total_next;
    logic               ovf_reg, ovf_next;

    logic               out_valid_reg, out_valid_next;
    logic [63:0]        out_data_reg, out_data_next;
    logic               out_last_reg, out_last_next;
    logic [OFS_W-1:0]   out_total_reg, out_total_next;
    logic               out_ovf_reg, out_ovf_next;

    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic [7:0]         wr_be;
    logic [63:0]        wr_data;
    logic               rd_en;
    logic [ADDR_W-1:0]  rd_addr;

    logic               load;
    logic               is_last;
    logic [WCNT_W-1:0]  idx_inc;

    // The output register takes a new word when empty or being drained.
    assign load    = (state_reg == B_LOAD) && (!out_valid_reg || out_ready);
    assign idx_inc = WCNT_W'(idx_reg) + 1'b1;
    assign is_last = (idx_inc == words_reg);

    assign out_valid   = out_valid_reg;
    assign data_word   = out_data_reg;
    assign last_word   = out_last_reg;
    assign total_bytes = out_total_reg;
    assign overflowed  = out_ovf_reg;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE:
            begin
                if (!q_status.empty && (q_cmd.kind == CMD_EMIT))
                begin
                    state_next = B_LOAD;
                end
            end
            B_LOAD:
            begin
                if (load && is_last)
                begin
                    state_next = B_IDLE;
                end
            end
            default:
                state_next = B_IDLE;
        endcase
    end

    // Memory control and stream registers.
    always_comb
    begin
        pop            = 1'b0;
        wr_en          = 1'b0;
        wr_addr        = q_cmd.addr;
        wr_be          = q_cmd.be;
        wr_data        = q_cmd.data;
        rd_en          = 1'b0;
        rd_addr        = '0;
        idx_next       = idx_reg;
        words_next     = words_reg;
        total_next     = total_reg;
        ovf_next       = ovf_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        out_total_next = out_total_reg;
        out_ovf_next   = out_ovf_reg;
        case (state_reg)
            B_IDLE:
            begin
                if (!q_status.empty)
                begin
                    pop = 1'b1;
                    case (q_cmd.kind)
                        CMD_WRITE:
                        begin
                            wr_en = 1'b1;
                        end
                        CMD_EMIT:
                        begin
                            words_next = q_cmd.words;
                            total_next = q_cmd.total;
                            ovf_next   = q_cmd.ovf;
                            rd_en      = 1'b1;
                            rd_addr    = '0;
                            idx_next   = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            B_LOAD:
            begin
                if (load)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = rd_data_reg;
                    out_last_next  = is_last;
                    out_total_next = total_reg;
                    out_ovf_next   = ovf_reg;
                    if (!is_last)
                    begin
                        // Fetch the following word behind this one.
                        rd_en    = 1'b1;
                        rd_addr  = ADDR_W'(idx_inc);
                        idx_next = ADDR_W'(idx_inc);
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // Message buffer with byte lanes and a registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            for (int j = 0; j < 8; j++)
            begin
                if (wr_be[j])
                begin
                    mem[wr_addr][8*j +: 8] <= wr_data[8*j +: 8];
                end
            end
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Stream payload.
    always_ff @(posedge clk)
    begin
        idx_reg       <= idx_next;
        words_reg     <= words_next;
        total_reg     <= total_next;
        ovf_reg       <= ovf_next;
        out_data_reg  <= out_data_next;
        out_last_reg  <= out_last_next;
        out_total_reg <= out_total_next;
        out_ovf_reg   <= out_ovf_next;
    end

endmodule

`default_nettype wire

### rtl/tlv_message_framer_top.sv
// Top level of the TLV message framer: front end, command queue and back end.
//
//  Channel   Handshake              Beat contents
//  --------  ---------------------  ------------------------------------------
//  input     in_valid / in_ready    mode, field_id, value
//  output    out_valid / out_ready  data_word, last_word, total_bytes, overflowed
//  config    cfg_we                 stamp_message_id
//
// Start, character and unused items are taken in the front end's idle state. An int16
// field then passes F_OP, an int32 field or string begin F_OP and F_OP2 (F_OP alone
// when dropped), and finalize F_OP, F_OP2 and F_EMIT; closing an open string first
// passes F_CLOSE_LEN and F_CLOSE_PAD. The front end issues one command a cycle while
// the four-entry queue is not full; the back end performs one buffer write a cycle
// while idle, and on finalize streams total_bytes/8 words, one per cycle unless stalled.
// Reset clears the control state only; the buffer is not cleared.
// in_ready falls while the front end sequences an item or the queue is full;
// a stalled output holds the stream and fills the queue behind it.
`default_nettype none

module tlv_message_framer_top import tmf_pkg::*; (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [2:0]        mode,
    input  wire logic [31:0]       field_id,
    input  wire logic [31:0]       value,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [63:0]            data_word,
    output logic                   last_word,
    output logic [OFS_W-1:0]       total_bytes,
    output logic                   overflowed,
    input  wire logic              cfg_we,
    input  wire logic              stamp_message_id
);

    qstat_t q_status;
    logic   push;
    cmd_t   push_cmd;
    logic   pop;
    cmd_t   pop_cmd;

    // Item decode and layout.
    tmf_front u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .mode             (mode),
        .field_id         (field_id),
        .value            (value),
        .cfg_we           (cfg_we),
        .stamp_message_id (stamp_message_id),
        .q_status         (q_status),
        .push             (push),
        .push_cmd         (push_cmd)
    );

    // Command queue.
    tmf_cmd_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .pop_cmd  (pop_cmd),
        .status   (q_status)
    );

    // Buffer and output stream.
    tmf_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_status    (q_status),
        .q_cmd       (pop_cmd),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .data_word   (data_word),
        .last_word   (last_word),
        .total_bytes (total_bytes),
        .overflowed  (overflowed)
    );

endmodule

`default_nettype wire

### rtl/tmf_checker.sv
// Port-level checks on the framer's output stream, bound to the top level.
`default_nettype none

module tmf_checker import tmf_pkg::*; (
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             out_valid,
    input wire logic             out_ready,
    input wire logic [63:0]      data_word,
    input wire logic             last_word,
    input wire logic [OFS_W-1:0] total_bytes,
    input wire logic             overflowed
);

    // A stalled output beat holds its contents.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(data_word) && $stable(last_word))
        else $error("output beat changed while stalled");

    // Message length is whole words, at least the header, within the buffer.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (total_bytes[2:0] == 3'd0) && (total_bytes >= OFS_W'(HEADER_BYTES))
                      && (total_bytes <= OFS_W'(CAP_BYTES)))
        else $error("total_bytes out of range");

    // A message streams without gaps until its last word.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last_word |=> out_valid)
        else $error("gap inside a message stream");

    // Length and overflow flag stay fixed across the words of one message.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last_word |=>
            $stable(total_bytes) && $stable(overflowed))
        else $error("message summary changed mid-stream");

endmodule

bind tlv_message_framer_top tmf_checker u_tmf_checker (.*);

`default_nettype wire
